FILE: sv/asb_pkg.sv
// Package for the accelerating setpoint buttons block.
// Holds the payload and configuration types, gesture mode codes and fixed constants.
// Depends on nothing; every other file imports it.
package asb_pkg;

  typedef struct packed {
    logic up_pressed;
    logic down_pressed;
  } asb_in_t;

  typedef struct packed {
    logic [9:0] setpoint;
    logic       changed;
    logic       menu_request;
  } asb_out_t;

  typedef struct packed {
    logic [9:0]  lower_limit;
    logic [9:0]  upper_limit;
    logic [11:0] first_hold_ticks;
    logic [11:0] menu_hold_ticks;
    logic [7:0]  settle_ticks;
  } asb_cfg_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_HOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MENU_HOLD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE       = 3'd4;

  localparam logic [9:0]  RST_LOWER_LIMIT = 10'd1;
  localparam logic [9:0]  RST_UPPER_LIMIT = 10'd999;
  localparam logic [11:0] RST_FIRST_HOLD  = 12'd400;
  localparam logic [11:0] RST_MENU_HOLD   = 12'd1500;
  localparam logic [7:0]  RST_SETTLE      = 8'd50;
  localparam logic [9:0]  RST_SETPOINT    = 10'd10;

  localparam int unsigned MODE_W = 3;
  localparam logic [MODE_W-1:0] M_IDLE     = 3'd0;
  localparam logic [MODE_W-1:0] M_BOTH     = 3'd1;
  localparam logic [MODE_W-1:0] M_UP_FIRST = 3'd2;
  localparam logic [MODE_W-1:0] M_DN_FIRST = 3'd3;
  localparam logic [MODE_W-1:0] M_UP_REP   = 3'd4;
  localparam logic [MODE_W-1:0] M_DN_REP   = 3'd5;
  localparam logic [MODE_W-1:0] M_WAIT     = 3'd6;
  localparam logic [MODE_W-1:0] M_SETTLE   = 3'd7;

  localparam logic [13:0] HOLD_MAX      = 14'd16383;
  localparam logic [13:0] HOLD_NO_STEP  = 14'd1000;
  localparam logic [13:0] HOLD_MID      = 14'd3000;
  localparam logic [13:0] HOLD_FAST     = 14'd8000;
  localparam logic [8:0]  PERIOD_SLOW   = 9'd300;
  localparam logic [8:0]  PERIOD_MID    = 9'd170;
  localparam logic [8:0]  PERIOD_FAST   = 9'd100;

endpackage

FILE: sv/asb_cfg_regs.sv
// Configuration register file for the accelerating setpoint buttons block.
// Decodes plain write-port transfers into the five settings; uses asb_pkg.
module asb_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [asb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output asb_pkg::asb_cfg_t             cfg
);
  import asb_pkg::*;

  asb_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lower_limit      <= RST_LOWER_LIMIT;
      cfg_r.upper_limit      <= RST_UPPER_LIMIT;
      cfg_r.first_hold_ticks <= RST_FIRST_HOLD;
      cfg_r.menu_hold_ticks  <= RST_MENU_HOLD;
      cfg_r.settle_ticks     <= RST_SETTLE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOWER_LIMIT: cfg_r.lower_limit      <= cfg_wdata[9:0];
        REG_UPPER_LIMIT: cfg_r.upper_limit      <= cfg_wdata[9:0];
        REG_FIRST_HOLD:  cfg_r.first_hold_ticks <= cfg_wdata;
        REG_MENU_HOLD:   cfg_r.menu_hold_ticks  <= cfg_wdata;
        REG_SETTLE:      cfg_r.settle_ticks     <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/asb_gesture.sv
// Gesture state and single-pass next-state logic for one tick.
// Holds mode, setpoint and counters; uses asb_pkg and the settings from asb_cfg_regs.
module asb_gesture (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tick,
  input  asb_pkg::asb_in_t    btn,
  input  asb_pkg::asb_cfg_t   cfg,
  output asb_pkg::asb_out_t   result
);
  import asb_pkg::*;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [9:0]        sp_r, sp_nxt;
  logic [13:0]       hold_r, hold_nxt;
  logic [8:0]        pace_r, pace_nxt;
  logic [7:0]        settle_r, settle_nxt;

  logic        up, dn, changed, menu, dir, mine, other;
  logic [13:0] hold_inc;
  logic [8:0]  period, pace_base, pace_inc;
  logic [MODE_W-1:0] end_mode;

  always_comb begin
    up        = btn.up_pressed;
    dn        = btn.down_pressed;
    mode_nxt  = mode_r;
    sp_nxt    = sp_r;
    hold_nxt  = hold_r;
    pace_nxt  = pace_r;
    settle_nxt = settle_r;
    changed   = 1'b0;
    menu      = 1'b0;
    dir       = (mode_r == M_UP_FIRST) || (mode_r == M_UP_REP);
    mine      = dir ? up : dn;
    other     = dir ? dn : up;
    hold_inc  = (hold_r < HOLD_MAX) ? hold_r + 14'd1 : hold_r;
    end_mode  = (cfg.settle_ticks == 8'd0) ? M_IDLE : M_SETTLE;

    if (hold_inc < HOLD_MID) begin
      period = PERIOD_SLOW;
    end else if (hold_inc < HOLD_FAST) begin
      period = PERIOD_MID;
    end else begin
      period = PERIOD_FAST;
    end
    pace_base = (pace_r > period) ? 9'd0 : pace_r;
    pace_inc  = pace_base + 9'd1;

    case (mode_r)
      M_IDLE: begin
        if (up && dn) begin
          hold_nxt = 14'd0;
          mode_nxt = M_BOTH;
        end else if (up || dn) begin
          hold_nxt = 14'd0;
          mode_nxt = up ? M_UP_FIRST : M_DN_FIRST;
          if (up && sp_r < cfg.upper_limit) begin
            sp_nxt  = sp_r + 10'd1;
            changed = 1'b1;
          end else if (!up && sp_r > cfg.lower_limit) begin
            sp_nxt  = sp_r - 10'd1;
            changed = 1'b1;
          end
        end
      end
      M_BOTH: begin
        if (up && dn) begin
          hold_nxt = hold_inc;
          if (hold_inc >= {2'b00, cfg.menu_hold_ticks}) begin
            menu     = 1'b1;
            mode_nxt = M_WAIT;
          end
        end else begin
          mode_nxt   = end_mode;
          settle_nxt = cfg.settle_ticks;
        end
      end
      M_UP_FIRST, M_DN_FIRST: begin
        if (mine && !other) begin
          hold_nxt = hold_inc;
          if (hold_inc >= {2'b00, cfg.first_hold_ticks}) begin
            hold_nxt = 14'd0;
            pace_nxt = 9'd0;
            mode_nxt = dir ? M_UP_REP : M_DN_REP;
          end
        end else begin
          mode_nxt   = end_mode;
          settle_nxt = cfg.settle_ticks;
        end
      end
      M_UP_REP, M_DN_REP: begin
        if (!mine) begin
          mode_nxt   = end_mode;
          settle_nxt = cfg.settle_ticks;
        end else if (up && dn) begin
          hold_nxt = 14'd0;
          mode_nxt = M_BOTH;
        end else begin
          hold_nxt = hold_inc;
          if (hold_inc > HOLD_NO_STEP) begin
            if (pace_inc == period) begin
              pace_nxt = 9'd0;
              if (dir && sp_r < cfg.upper_limit) begin
                sp_nxt  = sp_r + 10'd1;
                changed = 1'b1;
              end else if (!dir && sp_r > cfg.lower_limit) begin
                sp_nxt  = sp_r - 10'd1;
                changed = 1'b1;
              end
            end else begin
              pace_nxt = pace_inc;
            end
          end
        end
      end
      M_WAIT: begin
        if (!up && !dn) begin
          mode_nxt   = end_mode;
          settle_nxt = cfg.settle_ticks;
        end
      end
      default: begin
        if (settle_r > 8'd0) begin
          settle_nxt = settle_r - 8'd1;
        end
        if (settle_r <= 8'd1) begin
          mode_nxt = M_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      sp_r     <= RST_SETPOINT;
      hold_r   <= 14'd0;
      pace_r   <= 9'd0;
      settle_r <= 8'd0;
    end else if (tick) begin
      mode_r   <= mode_nxt;
      sp_r     <= sp_nxt;
      hold_r   <= hold_nxt;
      pace_r   <= pace_nxt;
      settle_r <= settle_nxt;
    end
  end

  always_comb begin
    result.setpoint     = sp_nxt;
    result.changed      = changed;
    result.menu_request = menu;
  end

endmodule

FILE: sv/asb_out_buf.sv
// Two-entry result buffer: an output register and a skid register.
// Lets a new transfer in while a finished result is still stalled; uses asb_pkg.
module asb_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  asb_pkg::asb_out_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output asb_pkg::asb_out_t out_data
);
  import asb_pkg::*;

  logic     main_valid_r, skid_valid_r;
  asb_out_t main_r, skid_r;
  logic     take;

  assign take = main_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (main_valid_r && !take) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end else if (take) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_valid_r && !take) begin
        skid_r <= push_data;
      end else begin
        main_r <= push_data;
      end
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

FILE: sv/accelerating_setpoint_buttons_core.sv
// Accelerating setpoint buttons: one button tick in, one setpoint result out.
// Results go into the output register, or the skid register while it stalls.
// Throughput: one tick per cycle unless stalled, set by the gesture update.
// Two result entries are buffered, so input is stalled only when both are held.
// Synchronous active-low reset restores the settings and the idle gesture state.
// Uses asb_pkg, asb_cfg_regs, asb_gesture and asb_out_buf.
module accelerating_setpoint_buttons_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  asb_pkg::asb_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output asb_pkg::asb_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [asb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import asb_pkg::*;

  asb_cfg_t cfg;
  asb_out_t result;
  logic     accept, full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  asb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  asb_gesture u_gesture (
    .clk    (clk),
    .rst_n  (rst_n),
    .tick   (accept),
    .btn    (in_data),
    .cfg    (cfg),
    .result (result)
  );

  asb_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: tb/accelerating_setpoint_buttons_core_tb.sv
// Self-checking testbench for accelerating_setpoint_buttons_core.
// Button ticks go in over the valid/stall input channel, and each result transfer is compared
// against a cycle-free tracker of the gesture state. Depends on asb_pkg and the core RTL only.
`timescale 1ns / 100ps

module accelerating_setpoint_buttons_core_tb;
  import asb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  asb_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  asb_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_LOWER_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  accelerating_setpoint_buttons_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  asb_cfg_t          cfg_now;
  logic [MODE_W-1:0] mode;
  logic [9:0]        level;
  logic [13:0]       held;
  logic [8:0]        pace;
  logic [7:0]        lockout;
  asb_out_t          tick_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned steps_seen = 0;
  int unsigned menus_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycles = 0;

  function automatic logic nudge_setpoint(input logic dir);
    if (dir && level < cfg_now.upper_limit) begin
      level = level + 10'd1;
      return 1'b1;
    end
    if (!dir && level > cfg_now.lower_limit) begin
      level = level - 10'd1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void close_gesture();
    if (cfg_now.settle_ticks == 8'd0) begin
      mode = M_IDLE;
    end else begin
      lockout = cfg_now.settle_ticks;
      mode = M_SETTLE;
    end
  endfunction

  function automatic void bump_hold();
    if (held != HOLD_MAX) held = held + 14'd1;
  endfunction

  function automatic asb_out_t track_buttons(input asb_in_t t);
    asb_out_t    r;
    logic        up;
    logic        dn;
    logic        dir;
    logic        mine;
    logic        other;
    logic [8:0]  period;
    up = t.up_pressed;
    dn = t.down_pressed;
    r = '0;
    case (mode)
      M_IDLE: begin
        if (up && dn) begin
          held = '0;
          mode = M_BOTH;
        end else if (up || dn) begin
          r.changed = nudge_setpoint(up);
          held = '0;
          mode = up ? M_UP_FIRST : M_DN_FIRST;
        end
      end
      M_BOTH: begin
        if (up && dn) begin
          bump_hold();
          if (held >= {2'b00, cfg_now.menu_hold_ticks}) begin
            r.menu_request = 1'b1;
            mode = M_WAIT;
          end
        end else begin
          close_gesture();
        end
      end
      M_UP_FIRST, M_DN_FIRST: begin
        dir = (mode == M_UP_FIRST);
        mine = dir ? up : dn;
        other = dir ? dn : up;
        if (mine && !other) begin
          bump_hold();
          if (held >= {2'b00, cfg_now.first_hold_ticks}) begin
            held = '0;
            pace = '0;
            mode = dir ? M_UP_REP : M_DN_REP;
          end
        end else begin
          close_gesture();
        end
      end
      M_UP_REP, M_DN_REP: begin
        dir = (mode == M_UP_REP);
        mine = dir ? up : dn;
        if (!mine) begin
          close_gesture();
        end else if (up && dn) begin
          held = '0;
          mode = M_BOTH;
        end else begin
          bump_hold();
          if (held > HOLD_NO_STEP) begin
            if (held < HOLD_MID) period = PERIOD_SLOW;
            else if (held < HOLD_FAST) period = PERIOD_MID;
            else period = PERIOD_FAST;
            if (pace > period) pace = '0;
            pace = pace + 9'd1;
            if (pace == period) begin
              pace = '0;
              r.changed = nudge_setpoint(dir);
            end
          end
        end
      end
      M_WAIT: begin
        if (!up && !dn) close_gesture();
      end
      default: begin
        if (lockout != 8'd0) lockout = lockout - 8'd1;
        if (lockout == 8'd0) mode = M_IDLE;
      end
    endcase
    r.setpoint = level;
    return r;
  endfunction

  task automatic send_tick(input logic up, input logic dn);
    asb_in_t t;
    t.up_pressed = up;
    t.down_pressed = dn;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tick_results.push_back(track_buttons(t));
    ticks_sent++;
  endtask

  task automatic hold_levels(input logic up, input logic dn, input int unsigned n);
    repeat (n) send_tick(up, dn);
  endtask

  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (tick_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input asb_cfg_t c);
    settle_pipeline();
    cfg_we <= 1'b1;
    cfg_index <= REG_LOWER_LIMIT;
    cfg_wdata <= CFG_DATA_W'(c.lower_limit);
    @(posedge clk);
    cfg_index <= REG_UPPER_LIMIT;
    cfg_wdata <= CFG_DATA_W'(c.upper_limit);
    @(posedge clk);
    cfg_index <= REG_FIRST_HOLD;
    cfg_wdata <= CFG_DATA_W'(c.first_hold_ticks);
    @(posedge clk);
    cfg_index <= REG_MENU_HOLD;
    cfg_wdata <= CFG_DATA_W'(c.menu_hold_ticks);
    @(posedge clk);
    cfg_index <= REG_SETTLE;
    cfg_wdata <= CFG_DATA_W'(c.settle_ticks);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_now = c;
  endtask

  task automatic test_taps_and_limits();
    set_config('{lower_limit: 10'd9, upper_limit: 10'd12, first_hold_ticks: 12'd2,
                 menu_hold_ticks: 12'd2, settle_ticks: 8'd1});
    hold_levels(1'b0, 1'b0, 1);
    hold_levels(1'b1, 1'b0, 1);
    hold_levels(1'b0, 1'b0, 2);
    hold_levels(1'b1, 1'b0, 3);
    hold_levels(1'b0, 1'b0, 2);
    hold_levels(1'b1, 1'b0, 1);
    hold_levels(1'b0, 1'b0, 2);
    hold_levels(1'b0, 1'b1, 1);
    hold_levels(1'b1, 1'b1, 1);
    hold_levels(1'b0, 1'b0, 1);
    hold_levels(1'b1, 1'b1, 3);
    hold_levels(1'b1, 1'b0, 1);
    hold_levels(1'b0, 1'b0, 2);
    set_config('{lower_limit: 10'd1023, upper_limit: 10'd0, first_hold_ticks: 12'd2,
                 menu_hold_ticks: 12'd2, settle_ticks: 8'd1});
    hold_levels(1'b0, 1'b1, 1);
    hold_levels(1'b0, 1'b0, 2);
    hold_levels(1'b1, 1'b0, 1);
    hold_levels(1'b0, 1'b0, 2);
  endtask

  task automatic test_zero_holds();
    set_config('{lower_limit: 10'd0, upper_limit: 10'd1023, first_hold_ticks: 12'd0,
                 menu_hold_ticks: 12'd0, settle_ticks: 8'd0});
    hold_levels(1'b1, 1'b1, 2);
    hold_levels(1'b0, 1'b0, 1);
    hold_levels(1'b0, 1'b1, 2);
    hold_levels(1'b1, 1'b1, 2);
    hold_levels(1'b0, 1'b0, 1);
  endtask

  task automatic test_random_gestures(input int unsigned idle_pct, input int unsigned stall_pct);
    asb_cfg_t    c;
    int unsigned lo;
    int unsigned hi;
    int unsigned start;
    int unsigned k;
    int unsigned first;
    int unsigned menu;
    logic        dir;
    for (int p = 0; p < 2; p++) begin
      lo = $urandom_range(0, 20);
      hi = lo + $urandom_range(0, 20);
      if ($urandom_range(4) == 0) begin
        c.lower_limit = 10'(hi);
        c.upper_limit = 10'(lo);
      end else begin
        c.lower_limit = 10'(lo);
        c.upper_limit = 10'(hi);
      end
      c.first_hold_ticks = 12'($urandom_range(1, 12));
      c.menu_hold_ticks = 12'($urandom_range(1, 12));
      c.settle_ticks = 8'($urandom_range(0, 4));
      set_config(c);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      start = ticks_sent;
      while (ticks_sent - start < 15) begin
        k = $urandom_range(199);
        first = (cfg_now.first_hold_ticks == 0) ? 1 : cfg_now.first_hold_ticks;
        menu = (cfg_now.menu_hold_ticks == 0) ? 1 : cfg_now.menu_hold_ticks;
        dir = 1'($urandom_range(1));
        if (k < 60) begin
          hold_levels(1'b1, 1'b0, $urandom_range(1, first + 3));
        end else if (k < 120) begin
          hold_levels(1'b0, 1'b1, $urandom_range(1, first + 3));
        end else if (k < 150) begin
          hold_levels(1'b1, 1'b1, $urandom_range(1, menu + 3));
        end else if (k < 170) begin
          hold_levels(dir, !dir, first + $urandom_range(0, 5));
          hold_levels(1'b1, 1'b1, $urandom_range(1, menu + 2));
        end else begin
          repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        hold_levels(1'b0, 1'b0, $urandom_range(0, cfg_now.settle_ticks + 2));
      end
    end
  endtask

  task automatic test_long_hold();
    set_config('{lower_limit: 10'd0, upper_limit: 10'd100, first_hold_ticks: 12'd2,
                 menu_hold_ticks: 12'd3, settle_ticks: 8'd4});
    send_idle_pct = 34;
    recv_stall_pct = 34;
    hold_levels(1'b1, 1'b0, 1305);
    hold_levels(1'b1, 1'b1, 4);
    hold_levels(1'b0, 1'b0, 6);
    hold_levels(1'b0, 1'b1, 5);
    hold_levels(1'b0, 1'b0, 1);
  endtask

  always @(posedge clk) begin
    out_stall <= (rst_n && recv_stall_pct != 0) ? ($urandom_range(99) < recv_stall_pct) : 1'b0;
  end

  always @(posedge clk) begin
    asb_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tick_results.size() == 0) begin
        error_count++;
        $error("out_data: transfer with no tick outstanding, setpoint %0d", out_data.setpoint);
      end else begin
        want = tick_results.pop_front();
        results_seen++;
        if (want.changed) steps_seen++;
        if (want.menu_request) menus_seen++;
        if (out_data.setpoint !== want.setpoint) begin
          error_count++;
          $error("setpoint: expected %0d, got %0d", want.setpoint, out_data.setpoint);
        end
        if (out_data.changed !== want.changed) begin
          error_count++;
          $error("changed: expected %0b, got %0b", want.changed, out_data.changed);
        end
        if (out_data.menu_request !== want.menu_request) begin
          error_count++;
          $error("menu_request: expected %0b, got %0b", want.menu_request,
                 out_data.menu_request);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("accelerating_setpoint_buttons_core_tb: errors");
      $finish;
    end
  end

  initial begin
    cfg_now = '{lower_limit: RST_LOWER_LIMIT, upper_limit: RST_UPPER_LIMIT,
                first_hold_ticks: RST_FIRST_HOLD, menu_hold_ticks: RST_MENU_HOLD,
                settle_ticks: RST_SETTLE};
    mode = M_IDLE;
    level = RST_SETPOINT;
    held = '0;
    pace = '0;
    lockout = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_taps_and_limits();
    test_zero_holds();
    test_random_gestures(0, 0);
    test_random_gestures(74, 0);
    test_random_gestures(0, 74);
    test_random_gestures(34, 34);
    test_long_hold();
    settle_pipeline();
    $display("Sent %0d button ticks and checked %0d result transfers (%0d steps, %0d menu pulses).",
             ticks_sent, results_seen, steps_seen, menus_seen);
    $display("Covered taps, both-button holds, repeat past the first pace threshold and limits.");
    if (error_count == 0) begin
      $display("accelerating_setpoint_buttons_core_tb: clean");
    end else begin
      $display("accelerating_setpoint_buttons_core_tb: errors");
    end
    $finish;
  end

endmodule
